[rtl/core/cihp_pkg.sv]
package cihp_pkg;

  localparam int unsigned POS_W = 24;
  localparam logic [63:0] MIN_FILE_BYTES = 64'd12;

  // config register indexes
  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_VERSION = 2'd1;
  localparam logic [1:0] CFG_KIND    = 2'd2;
  localparam logic [1:0] CFG_TOTAL   = 2'd3;

  // result event codes
  localparam logic [1:0] EV_INDEX = 2'd0;
  localparam logic [1:0] EV_FILE  = 2'd1;
  localparam logic [1:0] EV_EMPTY = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SMALL     = 3'd1;
  localparam logic [2:0] ERR_MAGIC     = 3'd2;
  localparam logic [2:0] ERR_VERSION   = 3'd3;
  localparam logic [2:0] ERR_OVERRUN   = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;

  typedef enum logic [12:0] {
    PH_MAGIC    = 13'h0001,
    PH_VERSION  = 13'h0002,
    PH_COUNT    = 13'h0004,
    PH_KIND     = 13'h0008,
    PH_RESERVED = 13'h0010,
    PH_ID       = 13'h0020,
    PH_SUFLEN   = 13'h0040,
    PH_SUFSTR   = 13'h0080,
    PH_NFILES   = 13'h0100,
    PH_NAMELEN  = 13'h0200,
    PH_NAMESTR  = 13'h0400,
    PH_OFFSET   = 13'h0800,
    PH_LENGTH   = 13'h1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_data;
  } in_t;

  typedef struct packed {
    logic [1:0]        event_res;
    logic [2:0]        error_code;
    logic              header_done;
    logic              kind_known;
    logic signed [63:0] entry_id;
    logic [31:0]       file_count;
    logic [POS_W-1:0]  text_pos;
    logic [31:0]       text_len;
    logic [63:0]       file_offset;
    logic [63:0]       file_length;
  } out_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [31:0] version;
    logic [7:0]  kind;
    logic [63:0] total;
  } cfg_t;

  typedef struct packed {
    logic             finished;
    phase_t           phase;
    logic [2:0]       byte_cnt;
    logic [63:0]      shift;
    logic [POS_W-1:0] pos;
    logic [31:0]      indices_left;
    logic [31:0]      files_left;
    logic [31:0]      str_left;
    logic             kind_known;
    logic [63:0]      entry_id;
    logic [POS_W-1:0] text_pos;
    logic [31:0]      text_len;
    logic [63:0]      offset;
  } state_t;

  localparam state_t RESET_STATE = '{
    finished: 1'b1, phase: PH_MAGIC, byte_cnt: 3'd0, shift: 64'd0, pos: '0,
    indices_left: 32'd0, files_left: 32'd0, str_left: 32'd0, kind_known: 1'b0,
    entry_id: 64'd0, text_pos: '0, text_len: 32'd0, offset: 64'd0};

  // index of the last byte of a numeric field
  function automatic logic [2:0] field_last(phase_t ph);
    logic [2:0] r;
    case (ph)
      PH_KIND:     r = 3'd0;
      PH_RESERVED: r = 3'd2;
      PH_ID:       r = 3'd7;
      PH_OFFSET:   r = 3'd7;
      PH_LENGTH:   r = 3'd7;
      default:     r = 3'd3;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/cihp_step.sv]
module cihp_step #(
  parameter int unsigned MAX_HEADER_BYTES = 16777216
) (
  input  cihp_pkg::state_t st,
  input  cihp_pkg::in_t    din,
  input  cihp_pkg::cfg_t   cfg,
  output cihp_pkg::state_t st_next,
  output cihp_pkg::out_t   res,
  output logic             res_valid
);
  import cihp_pkg::*;

  localparam logic [POS_W:0] MaxHdr = (POS_W+1)'(MAX_HEADER_BYTES);

  state_t         cur;
  logic [POS_W:0] pos_inc;
  logic [63:0]    shifted;
  logic [64:0]    span;
  logic           last;
  logic           done;
  logic           entry;
  logic [2:0]     err;

  always_comb begin
    cur = st;
    if (din.first_byte) begin
      cur = RESET_STATE;
      cur.finished = 1'b0;
    end
    st_next = cur;
    res = '0;
    res_valid = 1'b0;
    pos_inc = {1'b0, cur.pos} + {{POS_W{1'b0}}, 1'b1};
    shifted = {cur.shift[55:0], din.data_byte};
    span = {1'b0, cur.offset} + {1'b0, shifted};
    last = (cur.byte_cnt == field_last(cur.phase));
    done = 1'b0;
    entry = 1'b0;
    err = ERR_NONE;

    if (din.first_byte && (cfg.total < MIN_FILE_BYTES)) begin
      res.event_res = EV_ERROR;
      res.error_code = ERR_SMALL;
      res_valid = 1'b1;
      st_next.finished = 1'b1;
    end else if (!cur.finished) begin
      if (cur.phase == PH_SUFSTR || cur.phase == PH_NAMESTR) begin
        st_next.str_left = cur.str_left - 32'd1;
        if (st_next.str_left == 32'd0) begin
          st_next.phase = (cur.phase == PH_SUFSTR) ? PH_NFILES : PH_OFFSET;
        end
      end else if (!last) begin
        st_next.byte_cnt = cur.byte_cnt + 3'd1;
        st_next.shift = shifted;
      end else begin
        st_next.byte_cnt = 3'd0;
        st_next.shift = 64'd0;
        case (cur.phase)
          PH_MAGIC: begin
            if (shifted[31:0] != cfg.magic) err = ERR_MAGIC;
            else st_next.phase = PH_VERSION;
          end
          PH_VERSION: begin
            if (shifted[31:0] != cfg.version) err = ERR_VERSION;
            else st_next.phase = PH_COUNT;
          end
          PH_COUNT: begin
            st_next.indices_left = shifted[31:0];
            if (shifted[31:0] == 32'd0) begin
              done = 1'b1;
              res.event_res = EV_EMPTY;
            end else begin
              st_next.phase = PH_KIND;
            end
          end
          PH_KIND: begin
            st_next.kind_known = (shifted[7:0] == cfg.kind);
            st_next.phase = PH_RESERVED;
          end
          PH_RESERVED: st_next.phase = PH_ID;
          PH_ID: begin
            st_next.entry_id = shifted;
            st_next.phase = PH_SUFLEN;
          end
          PH_SUFLEN, PH_NAMELEN: begin
            st_next.text_pos = pos_inc[POS_W-1:0];
            st_next.text_len = shifted[31:0];
            st_next.str_left = shifted[31:0];
            // an empty string takes no bytes
            if (cur.phase == PH_SUFLEN) begin
              st_next.phase = (shifted[31:0] != 32'd0) ? PH_SUFSTR : PH_NFILES;
            end else begin
              st_next.phase = (shifted[31:0] != 32'd0) ? PH_NAMESTR : PH_OFFSET;
            end
          end
          PH_NFILES: begin
            st_next.files_left = shifted[31:0];
            st_next.indices_left = cur.indices_left - 32'd1;
            entry = 1'b1;
            res.event_res = EV_INDEX;
            res.kind_known = cur.kind_known;
            res.entry_id = cur.entry_id;
            res.file_count = shifted[31:0];
            res.text_pos = cur.text_pos;
            res.text_len = cur.text_len;
            if (shifted[31:0] != 32'd0) st_next.phase = PH_NAMELEN;
            else if (st_next.indices_left == 32'd0) done = 1'b1;
            else st_next.phase = PH_KIND;
          end
          PH_OFFSET: begin
            st_next.offset = shifted;
            st_next.phase = PH_LENGTH;
          end
          PH_LENGTH: begin
            // offset + length against total size, no wrap
            if (span > {1'b0, cfg.total}) begin
              err = ERR_OVERRUN;
            end else begin
              st_next.files_left = cur.files_left - 32'd1;
              entry = 1'b1;
              res.event_res = EV_FILE;
              res.text_pos = cur.text_pos;
              res.text_len = cur.text_len;
              res.file_offset = cur.offset;
              res.file_length = shifted;
              if (st_next.files_left != 32'd0) st_next.phase = PH_NAMELEN;
              else if (cur.indices_left == 32'd0) done = 1'b1;
              else st_next.phase = PH_KIND;
            end
          end
          default: st_next.phase = cur.phase;
        endcase
      end

      st_next.pos = pos_inc[POS_W-1:0];

      if (err != ERR_NONE) begin
        res = '0;
        res.event_res = EV_ERROR;
        res.error_code = err;
        res_valid = 1'b1;
        st_next.finished = 1'b1;
      end else if (done) begin
        res.header_done = 1'b1;
        res_valid = 1'b1;
        st_next.finished = 1'b1;
      end else if (din.end_of_data || pos_inc >= MaxHdr) begin
        res = '0;
        res.event_res = EV_ERROR;
        res.error_code = ERR_TRUNCATED;
        res_valid = 1'b1;
        st_next.finished = 1'b1;
      end else begin
        res_valid = entry;
      end
    end
  end

endmodule

[rtl/core/compound_index_header_parser.sv]
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------
// in       | input     | in_valid / in_ready  | in_data  (data_byte, flags)
// out      | output    | out_valid / out_ready| out_data (one result item)
// cfg      | input     | cfg_we               | cfg_index, cfg_data
//
// One header byte per cycle unless the result register stalls; an item is
// held in the input register and the parse step feeds the result register.
// The parse state updates in the same cycle the item leaves the input register.
// Synchronous reset clears control and config; the parser then waits for a
// first byte. A stalled result register holds the input register, and in_ready
// drops only when both are full.
module compound_index_header_parser #(
  parameter int unsigned MAX_HEADER_BYTES = 16777216
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cihp_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cihp_pkg::out_t   out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_data
);
  import cihp_pkg::*;

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  in_t    s1_data;
  logic   s1_valid;
  out_t   res;
  logic   res_valid;
  logic   advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  cihp_step #(
    .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
  ) u_step (
    .st        (st),
    .din       (s1_data),
    .cfg       (cfg),
    .st_next   (st_next),
    .res       (res),
    .res_valid (res_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC:   cfg.magic   <= cfg_data[31:0];
        CFG_VERSION: cfg.version <= cfg_data[31:0];
        CFG_KIND:    cfg.kind    <= cfg_data[7:0];
        CFG_TOTAL:   cfg.total   <= cfg_data;
        default:     cfg.total   <= cfg.total;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= RESET_STATE;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data <= res;
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import cihp_pkg::*;

  // header byte cap given to the parser under test
  localparam int HDR_CAP = 4096;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_MAGIC;
  logic [63:0] cfg_data = '0;

  compound_index_header_parser #(.MAX_HEADER_BYTES(HDR_CAP)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  in_t        byte_queue[$];
  out_t       expected_results[$];
  logic [7:0] hdr_bytes[$];
  int         idle_pct = 13;
  int         stall_pct = 13;
  int         mismatches = 0;
  int         bytes_made = 0;
  int         bytes_accepted = 0;
  int         n_index = 0, n_file = 0, n_empty = 0, n_error = 0;

  // configuration as the parser sees it
  logic [31:0] want_magic = '0;
  logic [31:0] want_version = '0;
  logic [7:0]  known_kind = '0;
  logic [63:0] total_bytes = '0;

  // parser state
  logic        hdr_idle = 1'b1;
  phase_t      hdr_phase = PH_MAGIC;
  logic [2:0]  fld_cnt = '0;
  logic [63:0] fld_acc = '0;
  logic [23:0] hdr_pos = '0;
  logic [31:0] idx_todo = '0, files_todo = '0, str_todo = '0;
  logic        kind_match = 1'b0;
  logic [63:0] id_latch = '0, off_latch = '0;
  logic [23:0] name_pos = '0;
  logic [31:0] name_len = '0;

  function automatic int field_bytes(phase_t ph);
    case (ph)
      PH_KIND: return 1;
      PH_RESERVED: return 3;
      PH_ID, PH_OFFSET, PH_LENGTH: return 8;
      default: return 4;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic reset_parser();
    hdr_phase = PH_MAGIC;
    fld_cnt = '0;
    fld_acc = '0;
    hdr_pos = '0;
    idx_todo = '0;
    files_todo = '0;
    str_todo = '0;
    kind_match = 1'b0;
    id_latch = '0;
    off_latch = '0;
    name_pos = '0;
    name_len = '0;
  endtask

  // advance the header parse by one byte, queue the result it produces
  task automatic parse_byte(input in_t it);
    out_t        r;
    logic [24:0] nxt;
    logic [63:0] acc;
    logic [31:0] w;
    logic [2:0]  err;
    logic        entry, done;
    r = '0;
    err = ERR_NONE;
    entry = 1'b0;
    done = 1'b0;
    if (it.first_byte) begin
      reset_parser();
      hdr_idle = 1'b0;
      if (total_bytes < MIN_FILE_BYTES) begin
        r.event_res = EV_ERROR;
        r.error_code = ERR_SMALL;
        hdr_idle = 1'b1;
        expected_results.insert(expected_results.size(), r);
        return;
      end
    end
    if (hdr_idle) return;
    nxt = {1'b0, hdr_pos} + 25'd1;
    if (hdr_phase == PH_SUFSTR || hdr_phase == PH_NAMESTR) begin
      str_todo = str_todo - 32'd1;
      if (str_todo == 0) begin
        if (hdr_phase == PH_SUFSTR) hdr_phase = PH_NFILES;
        else hdr_phase = PH_OFFSET;
      end
    end else begin
      fld_acc = {fld_acc[55:0], it.data_byte};
      if (int'(fld_cnt) + 1 < field_bytes(hdr_phase)) begin
        fld_cnt = fld_cnt + 3'd1;
      end else begin
        fld_cnt = '0;
        acc = fld_acc;
        fld_acc = '0;
        w = acc[31:0];
        case (hdr_phase)
          PH_MAGIC: begin
            if (w != want_magic) err = ERR_MAGIC;
            else hdr_phase = PH_VERSION;
          end
          PH_VERSION: begin
            if (w != want_version) err = ERR_VERSION;
            else hdr_phase = PH_COUNT;
          end
          PH_COUNT: begin
            idx_todo = w;
            if (w == 0) begin
              done = 1'b1;
              r.event_res = EV_EMPTY;
            end else begin
              hdr_phase = PH_KIND;
            end
          end
          PH_KIND: begin
            kind_match = (acc[7:0] == known_kind);
            hdr_phase = PH_RESERVED;
          end
          PH_RESERVED: hdr_phase = PH_ID;
          PH_ID: begin
            id_latch = acc;
            hdr_phase = PH_SUFLEN;
          end
          PH_SUFLEN, PH_NAMELEN: begin
            name_pos = nxt[23:0];
            name_len = w;
            str_todo = w;
            if (hdr_phase == PH_SUFLEN) begin
              if (w != 0) hdr_phase = PH_SUFSTR;
              else hdr_phase = PH_NFILES;
            end else begin
              if (w != 0) hdr_phase = PH_NAMESTR;
              else hdr_phase = PH_OFFSET;
            end
          end
          PH_NFILES: begin
            files_todo = w;
            idx_todo = idx_todo - 32'd1;
            entry = 1'b1;
            r.event_res = EV_INDEX;
            r.kind_known = kind_match;
            r.entry_id = id_latch;
            r.file_count = w;
            r.text_pos = name_pos;
            r.text_len = name_len;
            if (w != 0) hdr_phase = PH_NAMELEN;
            else if (idx_todo == 0) done = 1'b1;
            else hdr_phase = PH_KIND;
          end
          PH_OFFSET: begin
            off_latch = acc;
            hdr_phase = PH_LENGTH;
          end
          PH_LENGTH: begin
            // no wraparound: overrun if offset alone is past the end or length exceeds the room left
            if (off_latch > total_bytes || acc > total_bytes - off_latch) begin
              err = ERR_OVERRUN;
            end else begin
              files_todo = files_todo - 32'd1;
              entry = 1'b1;
              r.event_res = EV_FILE;
              r.text_pos = name_pos;
              r.text_len = name_len;
              r.file_offset = off_latch;
              r.file_length = acc;
              if (files_todo != 0) hdr_phase = PH_NAMELEN;
              else if (idx_todo == 0) done = 1'b1;
              else hdr_phase = PH_KIND;
            end
          end
          default: ;
        endcase
      end
    end
    hdr_pos = nxt[23:0];
    if (err != ERR_NONE) begin
      r = '0;
      r.event_res = EV_ERROR;
      r.error_code = err;
      hdr_idle = 1'b1;
      expected_results.insert(expected_results.size(), r);
    end else if (done) begin
      r.header_done = 1'b1;
      hdr_idle = 1'b1;
      expected_results.insert(expected_results.size(), r);
    end else if (it.end_of_data || nxt >= HDR_CAP) begin
      r = '0;
      r.event_res = EV_ERROR;
      r.error_code = ERR_TRUNCATED;
      hdr_idle = 1'b1;
      expected_results.insert(expected_results.size(), r);
    end else if (entry) begin
      expected_results.insert(expected_results.size(), r);
    end
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_data);
        bytes_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data <= byte_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result side
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, actual %0h",
                   $time, out_data);
        end else begin
          want = expected_results.pop_front();
          cmp_field("event_res", 64'(want.event_res), 64'(out_data.event_res));
          cmp_field("error_code", 64'(want.error_code), 64'(out_data.error_code));
          cmp_field("header_done", 64'(want.header_done), 64'(out_data.header_done));
          cmp_field("kind_known", 64'(want.kind_known), 64'(out_data.kind_known));
          cmp_field("entry_id", want.entry_id, out_data.entry_id);
          cmp_field("file_count", 64'(want.file_count), 64'(out_data.file_count));
          cmp_field("text_pos", 64'(want.text_pos), 64'(out_data.text_pos));
          cmp_field("text_len", 64'(want.text_len), 64'(out_data.text_len));
          cmp_field("file_offset", want.file_offset, out_data.file_offset);
          cmp_field("file_length", want.file_length, out_data.file_length);
          case (want.event_res)
            EV_INDEX: n_index++;
            EV_FILE: n_file++;
            EV_EMPTY: n_empty++;
            default: n_error++;
          endcase
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic wait_results();
    while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // quiet point: items with no result may still be in the pipe
  task automatic drain();
    wait_results();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MAGIC: want_magic = val[31:0];
      CFG_VERSION: want_version = val[31:0];
      CFG_KIND: known_kind = val[7:0];
      default: total_bytes = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] magic, input logic [31:0] version,
                            input logic [7:0] kind, input logic [63:0] total);
    write_reg(CFG_MAGIC, {32'd0, magic});
    write_reg(CFG_VERSION, {32'd0, version});
    write_reg(CFG_KIND, {56'd0, kind});
    write_reg(CFG_TOTAL, total);
  endtask

  task automatic add_be(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) hdr_bytes.insert(hdr_bytes.size(), v[8*i +: 8]);
  endtask

  // offset/length pair, mostly inside the file, sometimes on or past the end
  task automatic pick_extent(output logic [63:0] off, output logic [63:0] len);
    logic [63:0] room;
    int          r;
    r = $urandom_range(29);
    off = (total_bytes == '1) ? rand64() : rand64() % (total_bytes + 64'd1);
    room = total_bytes - off;
    if (r == 0) begin
      len = room + 64'd1;
    end else if (r == 1) begin
      off = rand64();
      len = rand64();
    end else if (r < 5) begin
      len = room;
    end else begin
      len = (room == '1) ? rand64() : rand64() % (room + 64'd1);
    end
  endtask

  // well-formed header with random content, occasionally bent out of shape
  task automatic build_header();
    int          n_idx, n_files, slen;
    logic [31:0] decl;
    logic [63:0] off, len;
    hdr_bytes.delete();
    if ($urandom_range(19) == 0) add_be(64'(want_magic ^ (32'd1 << $urandom_range(31))), 4);
    else add_be({32'd0, want_magic}, 4);
    if ($urandom_range(19) == 0) add_be(64'(want_version ^ (32'd1 << $urandom_range(31))), 4);
    else add_be({32'd0, want_version}, 4);
    n_idx = $urandom_range(3);
    decl = ($urandom_range(14) == 0) ? $urandom : n_idx;
    add_be({32'd0, decl}, 4);
    for (int i = 0; i < n_idx; i++) begin
      add_be({56'd0, ($urandom_range(1) != 0) ? known_kind : 8'($urandom_range(255))}, 1);
      add_be(64'($urandom), 3);
      add_be(rand64(), 8);
      slen = $urandom_range(5);
      add_be(64'(($urandom_range(29) == 0) ? $urandom : slen), 4);
      for (int k = 0; k < slen; k++) add_be(64'($urandom_range(255)), 1);
      n_files = $urandom_range(3);
      add_be(64'(($urandom_range(19) == 0) ? $urandom : n_files), 4);
      for (int f = 0; f < n_files; f++) begin
        slen = $urandom_range(5);
        add_be(64'(($urandom_range(29) == 0) ? $urandom : slen), 4);
        for (int k = 0; k < slen; k++) add_be(64'($urandom_range(255)), 1);
        pick_extent(off, len);
        add_be(off, 8);
        add_be(len, 8);
      end
    end
  endtask

  // queue the first cut bytes; optionally wait for all results before byte split
  task automatic send_header(input int cut, input bit eod_last, input int split);
    in_t it;
    for (int i = 0; i < cut; i++) begin
      if (split != 0 && i == split) wait_results();
      it.data_byte = hdr_bytes[i];
      it.first_byte = (i == 0);
      it.end_of_data = eod_last && (i == cut - 1);
      byte_queue.insert(byte_queue.size(), it);
    end
    bytes_made += cut;
  endtask

  initial begin
    int   budget, n, cut, split, made0;
    in_t  it;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: total size 0 is too small; a stray byte is then ignored
    it = '{data_byte: 8'hA5, first_byte: 1'b1, end_of_data: 1'b0};
    byte_queue.insert(byte_queue.size(), it);
    it = '{data_byte: 8'h5A, first_byte: 1'b0, end_of_data: 1'b1};
    byte_queue.insert(byte_queue.size(), it);
    drain();

    set_config(32'd0, 32'd0, 8'd0, 64'd12);
    hdr_bytes.delete();
    add_be(64'd0, 4);
    add_be(64'd0, 4);
    add_be(64'd0, 4);
    send_header(12, 1'b0, 0);         // empty header
    hdr_bytes.delete();
    add_be(64'd1, 4);
    send_header(4, 1'b0, 0);          // bad magic
    hdr_bytes.delete();
    add_be(64'd0, 4);
    add_be(64'h8000_0000, 4);
    send_header(8, 1'b1, 0);          // bad version on the last byte
    bytes_made = 0;

    for (int s = 0; s < 7; s++) begin
      drain();
      idle_pct = 13;
      stall_pct = 13;
      budget = 200;
      case (s)
        0: set_config('1, '1, 8'hFF, '1);
        1: begin
          set_config(32'd0, 32'd0, 8'd0, 64'd0);
          budget = 15;
        end
        2: begin
          set_config($urandom, $urandom, 8'($urandom), 64'd11);
          budget = 15;
        end
        3: begin
          set_config($urandom, $urandom, 8'($urandom), 64'd12);
          idle_pct = 0;
          stall_pct = 0;
          budget = 200;
        end
        4: set_config($urandom, $urandom, 8'($urandom), rand64());
        5: set_config($urandom, $urandom, 8'($urandom), 64'($urandom_range(65535)));
        default: begin
          set_config($urandom, $urandom, 8'($urandom), 64'h8000_0000_0000_0000);
          budget = 200;
        end
      endcase
      made0 = bytes_made;
      while (bytes_made - made0 < budget) begin
        build_header();
        n = hdr_bytes.size();
        cut = ($urandom_range(3) == 0) ? $urandom_range(n, 1) : n;
        split = ($urandom_range(9) == 0 && cut > 1) ? $urandom_range(cut - 1, 1) : 0;
        send_header(cut, 1'($urandom_range(1)), split);
        if ($urandom_range(4) == 0) begin
          for (int k = $urandom_range(3, 1); k > 0; k--) begin
            it.data_byte = 8'($urandom_range(255));
            it.first_byte = 1'b0;
            it.end_of_data = 1'($urandom_range(1));
            byte_queue.insert(byte_queue.size(), it);
          end
        end
      end
    end

    drain();
    $display("%0d bytes accepted under 9 register settings", bytes_accepted);
    $display("results checked: %0d index, %0d file, %0d empty header, %0d error",
             n_index, n_file, n_empty, n_error);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
